FILE: rtl/sseq_pkg.sv
// Shared types, constants and frequency tables for the step sequencer.
`default_nettype none
package sseq_pkg;
   localparam int NoteCapacity = 256;
   localparam int IdxBits = $clog2(NoteCapacity);
   localparam int CntBits = IdxBits + 1;
   localparam int ColumnBits = 16;
   localparam int FreqBits = 17;
   localparam int EntryBits = 1 + 3 + 4 + ColumnBits;

   typedef enum logic [2:0] {
      OP_TOGGLE = 3'd0, OP_QUERY = 3'd1, OP_TICK = 3'd2, OP_PLAY = 3'd3, OP_CLEAR = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      TONE_NONE = 2'd0, TONE_START = 2'd1, TONE_STOP = 2'd2
   } tone_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_MAX, ST_FIND, ST_MOVE, ST_DONE
   } state_type;

   typedef struct packed {
      logic             is_drum;
      logic [2:0]       octave;
      logic [3:0]       row;
      logic [ColumnBits-1:0] column;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic latch;     // capture the request
      logic scan_rst;  // restart the scan index
      logic scan_step; // advance the scan index
      logic max_upd;   // fold the read entry into the running maximum
      logic head_adv;  // advance the play head past the maximum
      logic find_chk;  // test the read entry against the play head
      logic match_chk; // test the read entry against the request
      logic finish;    // apply the simple opcodes and append
      logic move;      // write the last entry into the matched slot
      logic out_load;  // load the result register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       scan_end; // scan index reached the count
      logic       hit;      // a match or a column hit has been taken
      opcode_type op;
      logic       playing;
   } stat_type;

   function automatic logic [FreqBits-1:0] entry_freq(entry_type e, output logic ok);
      logic [16:0] px;
      logic [2:0] oc;
      logic [2:0] k;
      logic [17:0] sum;
      px = '0;
      ok = 1'b0;
      sum = '0;
      oc = (e.octave > 3'd4) ? 3'd4 : e.octave;
      k = 3'd4 - oc;
      if (e.is_drum) begin
         case (e.row)
            4'd0: begin entry_freq = 17'd120000; ok = 1'b1; end
            4'd1: begin entry_freq = 17'd32000; ok = 1'b1; end
            4'd2: begin entry_freq = 17'd1600; ok = 1'b1; end
            default: entry_freq = '0;
         endcase
      end else begin
         ok = (e.row < 4'd12);
         case (e.row)
            4'd0: px = 17'd66976;  4'd1: px = 17'd63217;  4'd2: px = 17'd59669;
            4'd3: px = 17'd56320;  4'd4: px = 17'd53159;  4'd5: px = 17'd50175;
            4'd6: px = 17'd47359;  4'd7: px = 17'd44701;  4'd8: px = 17'd42192;
            4'd9: px = 17'd39824;  4'd10: px = 17'd37589; 4'd11: px = 17'd35480;
            default: px = '0;
         endcase
         if (k == 3'd0) sum = {1'b0, px};
         else sum = ({1'b0, px} + (18'd1 << (k - 3'd1))) >> k;
         entry_freq = ok ? sum[FreqBits-1:0] : '0;
      end
   endfunction
endpackage
`default_nettype wire

FILE: rtl/sseq_ctrl.sv
// Controller state machine of the step sequencer.
`default_nettype none
module sseq_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   input  wire sseq_pkg::stat_type stat,
   output sseq_pkg::cmd_type      cmd
);
   sseq_pkg::state_type state_ff, state_in;
   logic out_valid_ff, out_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sseq_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // result register frees up on take
   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_tready) out_valid_in = 1'b0;
      if (cmd.out_load) out_valid_in = 1'b1;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sseq_pkg::ST_IDLE:
            if (req_tvalid) state_in = sseq_pkg::ST_SCAN;
         sseq_pkg::ST_SCAN: begin
            unique case (stat.op)
               sseq_pkg::OP_TOGGLE, sseq_pkg::OP_QUERY: state_in = sseq_pkg::ST_FIND;
               sseq_pkg::OP_TICK:
                  state_in = stat.playing ? sseq_pkg::ST_MAX : sseq_pkg::ST_DONE;
               default: state_in = sseq_pkg::ST_DONE;
            endcase
         end
         sseq_pkg::ST_MAX:
            if (stat.scan_end) state_in = sseq_pkg::ST_FIND;
         sseq_pkg::ST_FIND:
            if (stat.hit || stat.scan_end)
               state_in = (stat.op == sseq_pkg::OP_TOGGLE && stat.hit)
                          ? sseq_pkg::ST_MOVE : sseq_pkg::ST_DONE;
         sseq_pkg::ST_MOVE: state_in = sseq_pkg::ST_DONE;
         sseq_pkg::ST_DONE:
            if (!out_valid_ff || rsp_tready) state_in = sseq_pkg::ST_IDLE;
         default: state_in = sseq_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         sseq_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.latch = req_tvalid;
            cmd.scan_rst = req_tvalid;
         end
         sseq_pkg::ST_SCAN: ;
         sseq_pkg::ST_MAX: begin
            if (stat.scan_end) begin
               cmd.head_adv = 1'b1;
               cmd.scan_rst = 1'b1;
            end else begin
               cmd.max_upd = 1'b1;
               cmd.scan_step = 1'b1;
            end
         end
         sseq_pkg::ST_FIND: begin
            cmd.find_chk = (stat.op == sseq_pkg::OP_TICK);
            cmd.match_chk = (stat.op != sseq_pkg::OP_TICK);
            cmd.scan_step = !stat.hit && !stat.scan_end;
         end
         sseq_pkg::ST_MOVE: cmd.move = 1'b1;
         sseq_pkg::ST_DONE: begin
            if (!out_valid_ff || rsp_tready) begin
               cmd.finish = 1'b1;
               cmd.out_load = 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = out_valid_ff;
endmodule
`default_nettype wire

FILE: rtl/sseq_datapath.sv
// Note store, scan index, play head and result register.
`default_nettype none
module sseq_datapath (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [31:0]                req_tdata,
   input  wire sseq_pkg::cmd_type          cmd,
   output sseq_pkg::stat_type              stat,
   output logic [39:0]                     rsp_tdata
);
   localparam int CB = sseq_pkg::ColumnBits;
   localparam int IB = sseq_pkg::IdxBits;
   localparam int NB = sseq_pkg::CntBits;

   sseq_pkg::entry_type mem [sseq_pkg::NoteCapacity];
   sseq_pkg::entry_type rd_ff, last_ff;
   sseq_pkg::entry_type req_ff;
   sseq_pkg::entry_type hit_ent_ff;
   sseq_pkg::opcode_type op_ff;
   logic [NB-1:0] count_ff, idx_ff, hit_idx_ff;
   logic [NB-1:0] rd_idx_ff; // index of rd_ff, at or past count when none
   logic rd_ok_ff;
   logic [CB-1:0] head_ff, max_ff;
   logic playing_ff, hit_ff;
   logic [39:0] out_ff;
   sseq_pkg::entry_type req_in;
   logic wr_en;
   logic [IB-1:0] wr_addr;
   sseq_pkg::entry_type wr_data;
   logic [NB-1:0] last_idx;
   logic rd_match, col_hit;
   logic [sseq_pkg::FreqBits-1:0] freq;
   logic freq_ok;
   logic found, full;
   logic [1:0] act;
   logic [sseq_pkg::FreqBits-1:0] ofreq;

   assign req_in.is_drum = req_tdata[3];
   assign req_in.octave  = req_tdata[6:4];
   assign req_in.row     = req_tdata[10:7];
   assign req_in.column  = req_tdata[26:11];
   assign last_idx = count_ff - NB'(1);

   // read ports: the scan entry and the last entry are both read every cycle
   always_ff @(posedge clock) begin
      rd_ff <= mem[idx_ff[IB-1:0]];
      rd_idx_ff <= idx_ff;
      rd_ok_ff <= cmd.scan_step && (idx_ff < count_ff);
      last_ff <= mem[last_idx[IB-1:0]];
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   assign rd_match = rd_ok_ff && rd_ff.is_drum == req_ff.is_drum && rd_ff.row == req_ff.row
      && rd_ff.column == req_ff.column && (req_ff.is_drum || rd_ff.octave == req_ff.octave);
   assign col_hit = rd_ok_ff && rd_ff.column == head_ff;

   always_comb begin
      freq = sseq_pkg::entry_freq(hit_ent_ff, freq_ok);
   end

   always_comb begin
      wr_en = 1'b0;
      wr_addr = hit_idx_ff[IB-1:0];
      wr_data = last_ff;
      if (cmd.move) wr_en = 1'b1;
      else if (cmd.finish && op_ff == sseq_pkg::OP_TOGGLE && !hit_ff
               && count_ff < NB'(sseq_pkg::NoteCapacity)) begin
         wr_en = 1'b1;
         wr_addr = count_ff[IB-1:0];
         wr_data = req_ff;
      end
   end

   always_comb begin
      found = 1'b0; full = 1'b0; act = sseq_pkg::TONE_NONE; ofreq = '0;
      case (op_ff)
         sseq_pkg::OP_TOGGLE: begin
            found = !hit_ff && count_ff < NB'(sseq_pkg::NoteCapacity);
            full = !hit_ff && !found;
         end
         sseq_pkg::OP_QUERY: found = hit_ff;
         sseq_pkg::OP_TICK:
            if (playing_ff) begin
               act = (hit_ff && freq_ok) ? sseq_pkg::TONE_START : sseq_pkg::TONE_STOP;
               ofreq = (hit_ff && freq_ok) ? freq : '0;
            end
         sseq_pkg::OP_PLAY: act = playing_ff ? sseq_pkg::TONE_STOP : sseq_pkg::TONE_NONE;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         head_ff <= '0;
         playing_ff <= 1'b0;
         hit_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         if (cmd.latch) begin
            req_ff <= req_in;
            op_ff <= sseq_pkg::opcode_type'(req_tdata[2:0]);
            hit_ff <= 1'b0;
            max_ff <= '0;
         end
         if (cmd.scan_rst) idx_ff <= '0;
         else if (cmd.scan_step) idx_ff <= idx_ff + NB'(1);
         if (cmd.max_upd && rd_ok_ff && rd_ff.column > max_ff) max_ff <= rd_ff.column;
         if (cmd.head_adv) begin
            // fold the last entry read, then wrap
            if (rd_ok_ff && rd_ff.column > max_ff) begin
               if (head_ff + CB'(1) > rd_ff.column) head_ff <= '0;
               else head_ff <= head_ff + CB'(1);
            end else if (head_ff + CB'(1) > max_ff) head_ff <= '0;
            else head_ff <= head_ff + CB'(1);
         end
         if ((cmd.find_chk && col_hit) || (cmd.match_chk && rd_match)) begin
            hit_ff <= 1'b1;
            hit_idx_ff <= rd_idx_ff;
            hit_ent_ff <= rd_ff;
         end
         if (cmd.move) count_ff <= last_idx;
         if (cmd.out_load)
            out_ff <= {3'd0, (op_ff == sseq_pkg::OP_CLEAR) ? CB'(0)
                        : (op_ff == sseq_pkg::OP_PLAY && !playing_ff) ? req_ff.column
                        : head_ff, ofreq, act, full, found};
         if (cmd.finish) begin
            if (op_ff == sseq_pkg::OP_TOGGLE && found) count_ff <= count_ff + NB'(1);
            if (op_ff == sseq_pkg::OP_PLAY) begin
               playing_ff <= !playing_ff;
               if (!playing_ff) head_ff <= req_ff.column;
            end
            if (op_ff == sseq_pkg::OP_CLEAR) begin
               count_ff <= '0;
               head_ff <= '0;
            end
         end
      end
   end

   // read data and its index are registered from the scan index
   always_comb begin
      stat.op = op_ff;
      stat.playing = playing_ff;
      stat.hit = hit_ff || ((op_ff == sseq_pkg::OP_TICK) ? col_hit : rd_match);
      stat.scan_end = (rd_idx_ff >= count_ff) && !rd_ok_ff && (idx_ff >= count_ff);
   end

   assign rsp_tdata = out_ff;
endmodule
`default_nettype wire

FILE: rtl/step_sequencer_note_table.sv
// Top level of the step sequencer over an unordered note table.
// A toggle or query scans the table once before its response loads; a playing tick makes
// two passes (one for the largest column, one for the first hit); a stopped tick, play or
// clear loads its response without a scan. A held response stalls the sequencer.
// One request at a time; the next is taken in the cycle after the response loads.
// Reset: synchronous, clears count, play head and playing; the store is not cleared.
`default_nettype none
module step_sequencer_note_table (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // opcode[2:0], is_drum[3], octave[6:4], row[10:7], column[26:11]
   input  wire logic [31:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // found[0], table_full[1], tone_action[3:2], tone_freq_x16[20:4],
   // play_position[36:21]
   output logic [39:0]      rsp_tdata
);
   sseq_pkg::cmd_type cmd;
   sseq_pkg::stat_type stat;

   // sequence each request through scan passes
   sseq_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .stat, .cmd
   );

   // hold the table, play head and result
   sseq_datapath u_dp (
      .clock, .reset, .req_tdata, .cmd, .stat, .rsp_tdata
   );
endmodule
`default_nettype wire
